### hdl/tomr_pkg.sv
package tomr_pkg;

    localparam int MAX_DIMS     = 8;
    localparam int MAX_EXPONENT = 15;
    localparam int FIELD_COUNT  = 8;
    localparam int EXP_W        = 4;
    localparam int ND_W         = 4;
    localparam int RANK_W       = 41;
    localparam int IDX_W        = $clog2(MAX_DIMS);
    localparam int K_W          = $clog2(MAX_DIMS + 1);
    localparam int SUM_W        = $clog2(MAX_DIMS * MAX_EXPONENT + 1);
    localparam int N_MAX        = MAX_DIMS - 1 + MAX_DIMS * MAX_EXPONENT;
    localparam int N_W          = $clog2(N_MAX + 1);
    localparam int IN_DATA_W    = ((FIELD_COUNT * EXP_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((RANK_W + 7) / 8) * 8;

    typedef logic [EXP_W-1:0] t_exp;

    // one beat moving down the cell chain; lanes hold exponents last dimension first
    typedef struct packed {
        t_exp [MAX_DIMS-1:0] exps;
        logic [ND_W-1:0]     nd;
        logic [SUM_W-1:0]    sum;
        logic [RANK_W-1:0]   acc;
        logic [RANK_W-1:0]   term;
    } t_beat;

    typedef logic [N_MAX:0][MAX_DIMS:0][RANK_W-1:0] t_binom_tab;

    // Pascal triangle, modulo 2^RANK_W
    function automatic t_binom_tab build_binom();
        t_binom_tab t;
        t = '0;
        for (int n = 0; n <= N_MAX; n++) begin
            t[n][0] = RANK_W'(1);
            for (int k = 1; k <= MAX_DIMS; k++) begin
                if (n > 0) begin
                    t[n][k] = t[n-1][k] + t[n-1][k-1];
                end
            end
        end
        return t;
    endfunction

    localparam t_binom_tab BINOM_TAB = build_binom();

endpackage

### hdl/tomr_cell.sv
module tomr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tomr_pkg::IDX_W-1:0]  i_idx,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tomr_pkg::t_beat             i_beat,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tomr_pkg::t_beat             o_beat
);
    import tomr_pkg::*;

    logic             r_valid;
    t_beat            r_beat;
    t_beat            n_beat;
    logic [N_W-1:0]   w_n;
    logic [K_W-1:0]   w_k;
    logic             w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // this cell owns level k = idx+1: adds its exponent to the running tail sum
    // and looks up C(k-1+S, k); the term is folded into acc by the next stage
    always_comb begin
        n_beat      = i_beat;
        n_beat.sum  = i_beat.sum + SUM_W'(i_beat.exps[i_idx]);
        n_beat.acc  = i_beat.acc + i_beat.term;
        w_k         = K_W'(i_idx) + K_W'(1);
        w_n         = N_W'(i_idx) + N_W'(n_beat.sum);
        n_beat.term = '0;
        if (ND_W'(w_k) <= i_beat.nd) begin
            n_beat.term = BINOM_TAB[w_n][w_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### hdl/total_order_multiindex_rank.sv
// Rank of a multiindex in the total-degree basis. One 8x4-bit exponent vector per
// beat goes in, one 41-bit rank comes out, at a sustained rate of one beat per
// clock while the output is not stalled. The path is an input register that orders
// the lanes last dimension first, a chain of 8 cells (one per level, each with its
// own binomial lookup and accumulate), and an output register. Every stage keeps its
// own valid bit, so bubbles are squeezed out while the output is stalled. num_dims
// (reset 8, above 8 treated as 8) is sampled when a beat enters; write it only
// while the block is empty. Exponents of dimensions at or above num_dims are ignored.
module total_order_multiindex_rank (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tomr_pkg::ND_W-1:0]         i_cfg_data,   // num_dims
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tomr_pkg::IN_DATA_W-1:0]    i_s_tdata,    // exponent_0 .. exponent_7, 4 bits each
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tomr_pkg::OUT_DATA_W-1:0]   o_m_tdata     // rank[40:0], zero pad
);
    import tomr_pkg::*;

    logic [ND_W-1:0]   r_num_dims;
    logic [ND_W-1:0]   w_nd;
    t_exp [MAX_DIMS-1:0] w_exps;
    t_beat             n_in;
    t_beat             r_in;
    logic              r_in_valid;
    logic              w_in_ready;
    logic [ND_W-1:0]   w_src;

    logic [MAX_DIMS:0] w_valid;
    logic [MAX_DIMS:0] w_ready;
    t_beat             w_beat [MAX_DIMS+1];

    logic              r_out_valid;
    logic [RANK_W-1:0] r_rank;
    logic [ND_W-1:0]   r_out_nd;
    logic              w_out_ready;
    logic              w_lane_err;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= ND_W'(MAX_DIMS);
        end else if (i_cfg_valid) begin
            r_num_dims <= i_cfg_data;
        end
    end

    assign w_nd = (r_num_dims > ND_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS) : r_num_dims;

    // input stage: lane j carries dimension nd-1-j, lanes at or above nd are zero
    always_comb begin
        w_exps = '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (i < FIELD_COUNT) begin
                w_exps[i] = i_s_tdata[i*EXP_W +: EXP_W];
                if (w_exps[i] > EXP_W'(MAX_EXPONENT)) begin
                    w_exps[i] = EXP_W'(MAX_EXPONENT);
                end
            end
        end
        n_in  = '0;
        w_src = '0;
        n_in.nd = w_nd;
        for (int j = 0; j < MAX_DIMS; j++) begin
            w_src = w_nd - ND_W'(j) - ND_W'(1);
            if (ND_W'(j) < w_nd) begin
                n_in.exps[j] = w_exps[w_src[IDX_W-1:0]];
            end
        end
    end

    assign w_in_ready = !r_in_valid || w_ready[0];
    assign o_s_tready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && w_in_ready) begin
            r_in <= n_in;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_beat[0]  = r_in;

    // cell chain
    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
        tomr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    // output register folds in the last term
    assign w_out_ready       = !r_out_valid || i_m_tready;
    assign w_ready[MAX_DIMS] = w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[MAX_DIMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_valid[MAX_DIMS] && w_out_ready) begin
            r_rank   <= w_beat[MAX_DIMS].acc + w_beat[MAX_DIMS].term;
            r_out_nd <= w_beat[MAX_DIMS].nd;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_rank);

    // checks
    always_comb begin
        w_lane_err = 1'b0;
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (ND_W'(j) >= r_in.nd && r_in.exps[j] != '0) begin
                w_lane_err = 1'b1;
            end
        end
    end

    a_unused_lanes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> !w_lane_err)
        else $error("exponent lane beyond num_dims is not zero");

    a_zero_dims_zero_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nd == '0) |-> (r_rank == '0))
        else $error("nonzero rank with zero dimensions");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled while output is not back-pressured");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    a_nd_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_in.nd <= ND_W'(MAX_DIMS)))
        else $error("dimension count above maximum in pipeline");

endmodule
